>>> src/vmx_pkg.sv
// Package: opcodes, status codes, state encoding and helpers for the VM execute unit.
`timescale 1ns / 1ps
`default_nettype none
package vmx_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned CNT_W = 6;

  typedef enum logic [4:0] {
    OP_SYS  = 5'd0,  OP_JMP  = 5'd1,  OP_JZ   = 5'd2,  OP_JP   = 5'd3,
    OP_JN   = 5'd4,  OP_JNZ  = 5'd5,  OP_JNP  = 5'd6,  OP_JNN  = 5'd7,
    OP_NOT  = 5'd8,  OP_U9   = 5'd9,  OP_U10  = 5'd10, OP_U11  = 5'd11,
    OP_U12  = 5'd12, OP_U13  = 5'd13, OP_U14  = 5'd14, OP_STOP = 5'd15,
    OP_MOV  = 5'd16, OP_ADD  = 5'd17, OP_SUB  = 5'd18, OP_MUL  = 5'd19,
    OP_DIV  = 5'd20, OP_CMP  = 5'd21, OP_SHL  = 5'd22, OP_SHR  = 5'd23,
    OP_SAR  = 5'd24, OP_AND  = 5'd25, OP_OR   = 5'd26, OP_XOR  = 5'd27,
    OP_SWAP = 5'd28, OP_LDL  = 5'd29, OP_LDH  = 5'd30, OP_RND  = 5'd31
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_OP  = 3'd1,
    ST_DIV0    = 3'd2,
    ST_NEG_SH  = 3'd3,
    ST_IMM_WR  = 3'd4,
    ST_EXT_OP  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIX,
    S_DONE
  } state_e;

  localparam logic [1:0] FLAG_ZERO = 2'b01;
  localparam logic [1:0] FLAG_NEG  = 2'b10;
  localparam logic [31:0] HI_MASK = 32'hFFFF_0000;
  localparam logic [31:0] LO_MASK = 32'h0000_FFFF;

  function automatic logic [1:0] flags_of(input logic [XLEN-1:0] v);
    if (v == '0) return FLAG_ZERO;
    if (v[XLEN-1]) return FLAG_NEG;
    return 2'b00;
  endfunction

endpackage
`default_nettype wire

>>> src/vm_execute_unit.sv
// Execute stage of a small 32-bit VM with a serial divider.
//
// Usage: one decoded instruction is requested on the in channel
// (in_valid_i / in_ready_o); its single result request appears on the out
// channel (out_valid_o / out_ready_i). Both channels are valid/ready.
// Each request passes from S_IDLE through S_FIX, which computes the
// result into the output register, to S_DONE, where out_valid_o is high.
// A DIV with a nonzero divisor first runs a restoring divider in S_DIV,
// one quotient bit per cycle, before the fix-up in S_FIX. The block holds
// one request at a time: in_ready_o is high only in idle, so a new
// request is taken only after the last result has been accepted.
// The flags and remainder registers update when a result that sets them is
// formed without error and are shown on flags_out_o / remainder_out_o of that result.
// Reset clears flags, remainder and the sequencer; no output is valid.
// When the receiver stalls, the result is held in the output register
// and no new request is taken until it has been accepted.
`timescale 1ns / 1ps
`default_nettype none
module vm_execute_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [4:0]  kind_i,
  input  wire logic signed [31:0] first_value_i,
  input  wire logic signed [31:0] second_value_i,
  input  wire logic        first_writable_i,
  input  wire logic        second_writable_i,
  input  wire logic [15:0] jump_offset_i,
  input  wire logic [31:0] ip_after_fetch_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic signed [31:0] first_result_o,
  output logic             first_write_o,
  output logic signed [31:0] second_result_o,
  output logic             second_write_o,
  output logic [31:0]      next_ip_o,
  output logic             halt_o,
  output logic [2:0]       status_o,
  output logic [1:0]       flags_out_o,
  output logic signed [31:0] remainder_out_o
);
  import vmx_pkg::*;

  state_e state_q, state_d;
  logic [1:0]  flags_q;
  logic [31:0] rem_reg_q;

  // latched request
  logic [4:0]  kind_q;
  logic [31:0] a_q, b_q, ip_q;
  logic        wa_q, wb_q;
  logic [15:0] off_q;

  // divider: magnitudes, shifting partial remainder and quotient
  logic [31:0] dvd_q, dvs_q, quo_q, prem_q;
  logic [CNT_W-1:0] cnt_q;
  logic        neg_q_q, neg_r_q;

  // output register
  logic [31:0] r1_q, r2_q, nip_q;
  logic        w1_q, w2_q, halt_q;
  logic [2:0]  st_q;

  logic accept;
  assign accept = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (opcode_e'(kind_i) == OP_DIV && second_value_i != '0) state_d = S_DIV;
          else state_d = S_FIX;
        end
      end
      S_DIV: begin
        if (cnt_q == CNT_W'(XLEN - 1)) state_d = S_FIX;
      end
      S_FIX:  state_d = S_DONE;
      S_DONE: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    out_valid_o = (state_q == S_DONE);
  end

  // one restoring step
  logic [32:0] trial;
  logic [31:0] shrem;
  always_comb begin
    shrem = {prem_q[30:0], dvd_q[31]};
    trial = {1'b0, shrem} - {1'b0, dvs_q};
  end

  // finishing logic for the latched request
  logic [31:0] res, rem, qs, rs;
  logic        jump, setf, setr, w1, w2, hlt;
  logic [2:0]  st;
  logic [4:0]  sh;
  logic        big;
  always_comb begin
    res = '0; rem = '0; jump = 1'b0; setf = 1'b0; setr = 1'b0;
    w1 = 1'b0; w2 = 1'b0; hlt = 1'b0; st = ST_OK;
    big = (b_q[31:5] != '0);
    sh = b_q[4:0];
    qs = neg_q_q ? (32'd0 - quo_q) : quo_q;
    rs = neg_r_q ? (32'd0 - prem_q) : prem_q;
    case (opcode_e'(kind_q))
      OP_JMP: jump = 1'b1;
      OP_JZ:  jump = flags_q[0];
      OP_JP:  jump = (flags_q == 2'b00);
      OP_JN:  jump = flags_q[1];
      OP_JNZ: jump = !flags_q[0];
      OP_JNP: jump = (flags_q != 2'b00);
      OP_JNN: jump = !flags_q[1];
      OP_NOT: begin res = ~a_q; w1 = 1'b1; setf = 1'b1; end
      OP_STOP: hlt = 1'b1;
      OP_MOV: begin res = b_q; w1 = 1'b1; end
      OP_ADD: begin res = a_q + b_q; w1 = 1'b1; setf = 1'b1; end
      OP_SUB: begin res = a_q - b_q; w1 = 1'b1; setf = 1'b1; end
      OP_MUL: begin res = a_q * b_q; w1 = 1'b1; setf = 1'b1; end
      OP_DIV: begin
        if (b_q == '0) st = ST_DIV0;
        else begin
          // truncated quotient/remainder, then floor correction
          if (rs != '0 && (rs[31] != b_q[31])) begin
            res = qs - 32'd1;
            rem = rs + b_q;
          end else begin
            res = qs;
            rem = rs;
          end
          w1 = 1'b1; setf = 1'b1; setr = 1'b1;
        end
      end
      OP_CMP: begin res = a_q - b_q; setf = 1'b1; end
      OP_SHL: begin
        if (b_q[31]) st = ST_NEG_SH;
        else begin res = big ? '0 : (a_q << sh); w1 = 1'b1; setf = 1'b1; end
      end
      OP_SHR: begin
        if (b_q[31]) st = ST_NEG_SH;
        else begin res = big ? '0 : (a_q >> sh); w1 = 1'b1; setf = 1'b1; end
      end
      OP_SAR: begin
        if (b_q[31]) st = ST_NEG_SH;
        else begin
          res = $signed(a_q) >>> (big ? 5'd31 : sh);
          w1 = 1'b1; setf = 1'b1;
        end
      end
      OP_AND: begin res = a_q & b_q; w1 = 1'b1; setf = 1'b1; end
      OP_OR:  begin res = a_q | b_q; w1 = 1'b1; setf = 1'b1; end
      OP_XOR: begin res = a_q ^ b_q; w1 = 1'b1; setf = 1'b1; end
      OP_SWAP: begin res = b_q; w1 = 1'b1; w2 = 1'b1; end
      OP_LDL: begin res = (a_q & HI_MASK) | (b_q & LO_MASK); w1 = 1'b1; end
      OP_LDH: begin res = (a_q & LO_MASK) | {b_q[15:0], 16'h0000}; w1 = 1'b1; end
      OP_SYS, OP_RND: st = ST_EXT_OP;
      default: st = ST_BAD_OP;
    endcase
    if (st == ST_OK && ((w1 && !wa_q) || (w2 && !wb_q))) st = ST_IMM_WR;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      flags_q   <= '0;
      rem_reg_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FIX && st == ST_OK) begin
        if (setf) flags_q <= flags_of(res);
        if (setr) rem_reg_q <= rem;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      a_q    <= first_value_i;
      b_q    <= second_value_i;
      wa_q   <= first_writable_i;
      wb_q   <= second_writable_i;
      off_q  <= jump_offset_i;
      ip_q   <= ip_after_fetch_i;
      dvd_q  <= first_value_i[31] ? (32'd0 - first_value_i) : first_value_i;
      dvs_q  <= second_value_i[31] ? (32'd0 - second_value_i) : second_value_i;
      neg_q_q <= first_value_i[31] ^ second_value_i[31];
      neg_r_q <= first_value_i[31];
      prem_q <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
    end else if (state_q == S_DIV) begin
      dvd_q <= {dvd_q[30:0], 1'b0};
      cnt_q <= cnt_q + CNT_W'(1);
      if (!trial[32]) begin
        prem_q <= trial[31:0];
        quo_q  <= {quo_q[30:0], 1'b1};
      end else begin
        prem_q <= shrem;
        quo_q  <= {quo_q[30:0], 1'b0};
      end
    end
    if (state_q == S_FIX) begin
      st_q   <= st;
      w1_q   <= (st == ST_OK) && w1;
      w2_q   <= (st == ST_OK) && w2;
      r1_q   <= ((st == ST_OK) && w1) ? res : '0;
      r2_q   <= ((st == ST_OK) && w2) ? a_q : '0;
      halt_q <= (st == ST_OK) && hlt;
      nip_q  <= ((st == ST_OK) && jump) ? {ip_q[31:16], off_q} : ip_q;
    end
  end

  assign first_result_o  = r1_q;
  assign first_write_o   = w1_q;
  assign second_result_o = r2_q;
  assign second_write_o  = w2_q;
  assign next_ip_o       = nip_q;
  assign halt_o          = halt_q;
  assign status_o        = st_q;
  assign flags_out_o     = flags_q;
  assign remainder_out_o = rem_reg_q;

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(first_result_o))
    else $error("result dropped under stall");
  a_err_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (!first_write_o && !second_write_o && !halt_o))
    else $error("write on error");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q != CNT_W'(XLEN - 1)) |=> state_q == S_DIV)
    else $error("divider ended early");
endmodule
`default_nettype wire
